FILE: rtl/core/jsu_pkg.sv
// Shared types and character constants for the JSON string unescape block.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BODY  = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX0  = 3'd3,
    PH_HEX1  = 3'd4,
    PH_HEX2  = 3'd5,
    PH_HEX3  = 3'd6,
    PH_DRAIN = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One group holds every result that a single input byte causes.
  typedef struct packed {
    logic [1:0]      cnt;
    kind_e           kind;
    logic [2:0][7:0] data;
    logic [7:0]      len;
  } grp_t;

  localparam logic [8:0] CapReset = 9'd128;
  localparam logic [8:0] CapMax   = 9'd256;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChFf    = 8'h0C;

  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

endpackage

FILE: rtl/core/json_string_unescape_utf8.sv
// Top level: one raw byte per cycle in, a queue of decoded results out.
// Throughput is one byte per cycle while the group queue has room; a \u escape that becomes
// two or three UTF-8 bytes needs that many result transfers, which the queue absorbs.
// Path: a byte's group enters the queue at its input transfer edge, and the result register
// loads it from the queue once the back end is free.
// Reset clears phase, code point, stored count and queue; capacity returns to 128.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       line_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] stored_length_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic accept;
  logic grp_valid;
  grp_t grp_in;
  grp_t grp_out;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // A byte is taken whenever the queue has room for the group it may create. The
  // front end updates its state at the same edge, so bytes that produce nothing
  // (whitespace, an opening quote, a backslash, all but the last hex digit) never touch the queue.
  assign full   = q_full;
  assign accept = push && !q_full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .line_end_i  (line_end_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp_in)
  );

  // Each entry carries every result of one input byte, so the back end can walk a
  // multi-byte UTF-8 sequence while the front end keeps parsing.
  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grp_valid),
    .wr_data_i (grp_in),
    .rd_i      (q_pop),
    .rd_data_o (grp_out),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // The back end presents one result at a time; last marks the final result that
  // belongs to the group it is walking.
  jsu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (grp_out),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .stored_length_o (stored_length_o),
    .last_o          (last_o)
  );

  // Completion and error results always stand alone in their group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_DATA) |-> last_o)
    else $error("completion or error result not marked last");

  // Only data results carry a byte and only completion carries a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((kind_o == KIND_DATA) || (out_byte_o == 8'd0)) &&
               ((kind_o == KIND_DONE) || (stored_length_o == 8'd0)))
    else $error("result fields not zero for their kind");

  // A full queue means the back end must be holding a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("queue full while no result is presented");

  // A result kind is never the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o != 2'd3))
    else $error("invalid result kind presented");

endmodule

FILE: rtl/core/jsu_front.sv
// Front end: parses raw bytes, tracks the string state and builds result groups.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          line_end_i,
  output logic          grp_valid_o,
  output jsu_pkg::grp_t grp_o
);
  import jsu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] cp_q, cp_d;
  logic [7:0]  stored_q, stored_d;
  logic [8:0]  cap_q;

  logic [8:0]  cap_eff;
  logic [9:0]  sum1, sum2, sum3;
  logic        fit1, fit2, fit3;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_next;
  logic        is_ws;
  logic        do_fail;
  logic        do_store;
  logic        do_emit;
  logic [7:0]  store_byte;
  grp_t        grp;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cap_eff = (cap_q > CapMax) ? CapMax : cap_q;
  assign sum1    = {2'b00, stored_q} + 10'd1;
  assign sum2    = {2'b00, stored_q} + 10'd2;
  assign sum3    = {2'b00, stored_q} + 10'd3;
  assign fit1    = sum1 < {1'b0, cap_eff};
  assign fit2    = sum2 < {1'b0, cap_eff};
  assign fit3    = sum3 < {1'b0, cap_eff};
  assign cp_next = {cp_q[11:0], hex_val};
  assign is_ws   = (in_byte_i == ChSpace) || (in_byte_i == ChTab) ||
                   (in_byte_i == ChLf) || (in_byte_i == ChCr);

  always_comb begin
    phase_d    = phase_q;
    cp_d       = cp_q;
    stored_d   = stored_q;
    do_fail    = 1'b0;
    do_store   = 1'b0;
    do_emit    = 1'b0;
    store_byte = in_byte_i;
    grp        = '0;

    unique case (phase_q)
      PH_IDLE: begin
        if (is_ws) begin
          do_fail = line_end_i;
        end else if (in_byte_i != ChQuote || line_end_i) begin
          do_fail = 1'b1;
        end else begin
          stored_d = '0;
          phase_d  = PH_BODY;
        end
      end
      PH_BODY: begin
        if (in_byte_i == ChQuote) begin
          phase_d  = PH_IDLE;
          grp.cnt  = 2'd1;
          grp.kind = KIND_DONE;
          grp.len  = stored_q;
        end else if (line_end_i) begin
          do_fail = 1'b1;
        end else if (in_byte_i == ChBslash) begin
          phase_d = PH_ESC;
        end else begin
          do_store = 1'b1;
        end
      end
      PH_ESC: begin
        if (line_end_i) begin
          do_fail = 1'b1;
        end else begin
          phase_d = PH_BODY;
          case (in_byte_i)
            8'h6E:   store_byte = ChLf;
            8'h72:   store_byte = ChCr;
            8'h74:   store_byte = ChTab;
            8'h62:   store_byte = ChBs;
            8'h66:   store_byte = ChFf;
            default: store_byte = in_byte_i;
          endcase
          if (in_byte_i == 8'h75) begin
            cp_d    = '0;
            phase_d = PH_HEX0;
          end else begin
            do_store = 1'b1;
          end
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!hex_ok || line_end_i) begin
          do_fail = 1'b1;
        end else begin
          cp_d = cp_next;
          if (phase_q == PH_HEX3) begin
            phase_d = PH_BODY;
            do_emit = 1'b1;
          end else begin
            phase_d = phase_e'(phase_q + 3'd1);
          end
        end
      end
      PH_DRAIN: begin
        if (line_end_i) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    if (do_fail) begin
      grp.cnt  = 2'd1;
      grp.kind = KIND_ERROR;
      phase_d  = line_end_i ? PH_IDLE : PH_DRAIN;
    end

    // A single byte, either plain or from an escape or a short code point.
    if (do_store || (do_emit && cp_next < 16'h0080)) begin
      if (fit1) begin
        stored_d    = sum1[7:0];
        grp.cnt     = 2'd1;
        grp.kind    = KIND_DATA;
        grp.data[0] = do_emit ? cp_next[7:0] : store_byte;
      end
    end else if (do_emit && cp_next < 16'h0800) begin
      if (fit2) begin
        stored_d    = sum2[7:0];
        grp.cnt     = 2'd2;
        grp.kind    = KIND_DATA;
        grp.data[0] = Utf8Lead2 | {3'b000, cp_next[10:6]};
        grp.data[1] = Utf8Cont | {2'b00, cp_next[5:0]};
      end
    end else if (do_emit) begin
      if (fit3) begin
        stored_d    = sum3[7:0];
        grp.cnt     = 2'd3;
        grp.kind    = KIND_DATA;
        grp.data[0] = Utf8Lead3 | {4'b0000, cp_next[15:12]};
        grp.data[1] = Utf8Cont | {2'b00, cp_next[11:6]};
        grp.data[2] = Utf8Cont | {2'b00, cp_next[5:0]};
      end
    end
  end

  assign grp_o       = grp;
  assign grp_valid_o = accept_i && (grp.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cp_q     <= '0;
      stored_q <= '0;
      cap_q    <= CapReset;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q  <= phase_d;
        cp_q     <= cp_d;
        stored_q <= stored_d;
      end
    end
  end

endmodule

FILE: rtl/core/jsu_fifo.sv
// Small group queue between the parser front end and the result back end.
module jsu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  jsu_pkg::grp_t wr_data_i,
  input  logic          rd_i,
  output jsu_pkg::grp_t rd_data_o,
  output logic          full_o,
  output logic          empty_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = cnt_q == CntFull;
  assign empty_o   = cnt_q == '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/jsu_back.sv
// Back end: holds one result group and hands its results out one per transfer.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  jsu_pkg::grp_t q_data_i,
  output logic          q_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [1:0]    kind_o,
  output logic [7:0]    out_byte_o,
  output logic [7:0]    stored_length_o,
  output logic          last_o
);
  import jsu_pkg::*;

  grp_t       grp_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       is_last;
  logic       done;

  assign is_last = idx_q == (grp_q.cnt - 2'd1);
  assign done    = busy_q && pop_i && is_last;
  assign q_pop_o = !q_empty_i && (!busy_q || done);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      grp_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && pop_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign empty_o         = !busy_q;
  assign kind_o          = grp_q.kind;
  assign out_byte_o      = grp_q.data[idx_q];
  assign stored_length_o = grp_q.len;
  assign last_o          = is_last;

endmodule

FILE: sim/json_unescape_checker.sv
// Scoreboard for the JSON string unescape block: predicts decoded results and compares transfers.
module json_unescape_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_byte_i,
  input  logic       line_end_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] out_byte_i,
  input  logic [7:0] stored_length_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);
  import jsu_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] len;
    logic       last;
  } decoded_t;

  decoded_t    decoded_q[$];
  logic [8:0]  cap_q;
  phase_e      phase_q;
  logic [15:0] cp_q;
  logic [7:0]  count_q;
  int          errors = 0;
  int          result_no = 0;

  assign fail_count_o = errors;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 200) begin
      $display("MISMATCH result %0d %s: got %0h, expected %0h", result_no, what, got, want);
    end
    errors++;
  endtask

  // Capacities above 256 behave as 256, so the count stays within 8 bits.
  function automatic bit room_for(input int unsigned size);
    int unsigned lim;
    lim = (cap_q > CapMax) ? CapMax : cap_q;
    return (count_q + size) < lim;
  endfunction

  task automatic raise_error(input logic le);
    decoded_q.push_back('{KIND_ERROR, 8'h00, 8'h00, 1'b1});
    phase_q = le ? PH_IDLE : PH_DRAIN;
  endtask

  task automatic store_char(input logic [7:0] b);
    if (room_for(1)) begin
      count_q++;
      decoded_q.push_back('{KIND_DATA, b, 8'h00, 1'b1});
    end
  endtask

  // A code point is stored whole or not at all.
  task automatic emit_utf8();
    if (cp_q < 16'h0080) begin
      store_char(cp_q[7:0]);
    end else if (cp_q < 16'h0800) begin
      if (room_for(2)) begin
        count_q = count_q + 8'd2;
        decoded_q.push_back('{KIND_DATA, Utf8Lead2 | {3'b000, cp_q[10:6]}, 8'h00, 1'b0});
        decoded_q.push_back('{KIND_DATA, Utf8Cont | {2'b00, cp_q[5:0]}, 8'h00, 1'b1});
      end
    end else if (room_for(3)) begin
      count_q = count_q + 8'd3;
      decoded_q.push_back('{KIND_DATA, Utf8Lead3 | {4'h0, cp_q[15:12]}, 8'h00, 1'b0});
      decoded_q.push_back('{KIND_DATA, Utf8Cont | {2'b00, cp_q[11:6]}, 8'h00, 1'b0});
      decoded_q.push_back('{KIND_DATA, Utf8Cont | {2'b00, cp_q[5:0]}, 8'h00, 1'b1});
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic le);
    int nib;
    case (phase_q)
      PH_IDLE: begin
        if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) begin
          if (le) raise_error(1'b1);
        end else if (c != ChQuote || le) begin
          raise_error(le);
        end else begin
          count_q = 8'h00;
          phase_q = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == ChQuote) begin
          phase_q = PH_IDLE;
          decoded_q.push_back('{KIND_DONE, 8'h00, count_q, 1'b1});
        end else if (le) begin
          raise_error(1'b1);
        end else if (c == ChBslash) begin
          phase_q = PH_ESC;
        end else begin
          store_char(c);
        end
      end
      PH_ESC: begin
        if (le) begin
          raise_error(1'b1);
        end else begin
          phase_q = PH_BODY;
          case (c)
            "n": store_char(ChLf);
            "r": store_char(ChCr);
            "t": store_char(ChTab);
            "b": store_char(ChBs);
            "f": store_char(ChFf);
            "u": begin
              cp_q = 16'h0000;
              phase_q = PH_HEX0;
            end
            default: store_char(c);
          endcase
        end
      end
      PH_DRAIN: begin
        if (le) phase_q = PH_IDLE;
      end
      default: begin
        if (c >= "0" && c <= "9") nib = c - "0";
        else if (c >= "a" && c <= "f") nib = c - "a" + 10;
        else if (c >= "A" && c <= "F") nib = c - "A" + 10;
        else nib = -1;
        if (nib < 0 || le) begin
          raise_error(le);
        end else begin
          cp_q = {cp_q[11:0], 4'(nib)};
          if (phase_q == PH_HEX3) begin
            phase_q = PH_BODY;
            emit_utf8();
          end else begin
            phase_q = phase_e'(phase_q + 3'd1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      decoded_q.delete();
      cap_q = CapReset;
      phase_q = PH_IDLE;
      cp_q = 16'h0000;
      count_q = 8'h00;
      pending_o <= 0;
    end else begin
      // Results leave before new bytes enter; a byte never shows up in the same cycle.
      if (pop_i && !empty_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("with nothing expected, kind", kind_i, -1);
        end else begin
          want = decoded_q.pop_front();
          if (kind_i != want.kind) report_mismatch("kind", kind_i, want.kind);
          if (out_byte_i != want.data) report_mismatch("out_byte", out_byte_i, want.data);
          if (stored_length_i != want.len)
            report_mismatch("stored_length", stored_length_i, want.len);
          if (last_i != want.last) report_mismatch("last", last_i, want.last);
        end
        result_no++;
      end
      if (cfg_we_i) cap_q = cfg_wdata_i;
      if (push_i && !full_i) decode_byte(in_byte_i, line_end_i);
      pending_o <= decoded_q.size();
    end
  end

endmodule

FILE: sim/tb_json_string_unescape_utf8.sv
// Testbench top: drives lines of text into the JSON string unescape block and gives the verdict.
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  // The block takes one byte per cycle while its queue has room; a byte's group is written into
  // the queue and then loaded into the result register. Bytes that cause no result (whitespace,
  // dropped characters, drained bytes) give no sign of being finished, so quiet phases wait
  // DrainCycles beyond that before touching the register.
  localparam int DrainCycles = 8;
  // Long receiver hold-off used to fill the block and push back on the input side.
  localparam int HoldCycles  = 300;
  // Cycles without any transfer before the run is declared hung. The longest legitimate
  // quiet stretch is the receiver hold-off above, a few gaps and the drain waits.
  localparam int StallLimit  = 3000;
  localparam int PhaseItems  = 16;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       line_end;
  logic       empty;
  logic       pop;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] stored_length;
  logic       last;
  int         fail_count;
  int         pending;

  // Bytes of the line being built, sent in order with line_end on the final one.
  logic [7:0] line_q[$];
  int         sent = 0;
  int         burst_left = 0;
  bit         hold_rx = 1'b0;

  json_string_unescape_utf8 DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte),
    .line_end_i      (line_end),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind),
    .out_byte_o      (out_byte),
    .stored_length_o (stored_length),
    .last_o          (last)
  );

  json_unescape_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .push_i          (push),
    .full_i          (full),
    .in_byte_i       (in_byte),
    .line_end_i      (line_end),
    .empty_i         (empty),
    .pop_i           (pop),
    .kind_i          (kind),
    .out_byte_i      (out_byte),
    .stored_length_i (stored_length),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One byte transfer. The sender works in bursts; when a burst runs out it drops push for
  // a random gap. The gap is never empty, so push is never lowered and raised in the
  // same step. Signals are sampled right after the edge, so full is its pre-edge value.
  task automatic send_byte(input logic [7:0] b, input logic le);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // Mostly short bursts, now and then a long one with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    push     <= 1'b1;
    in_byte  <= b;
    line_end <= le;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // Appends a \u escape for the given code point with hex digits in random case. A digit
  // position in bad_at is replaced by a byte that is not a hex digit.
  task automatic push_unicode(input logic [15:0] cp, input int bad_at);
    logic [3:0] nib;
    logic [7:0] b;
    line_q.push_back(ChBslash);
    line_q.push_back("u");
    for (int k = 0; k < 4; k++) begin
      nib = cp[15 - 4 * k -: 4];
      if (k == bad_at) begin
        do b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
      end else if (nib < 10) begin
        b = "0" + nib;
      end else begin
        b = 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
      end
      line_q.push_back(b);
    end
  endtask

  // A quoted string with a random mix of plain bytes, short escapes, pass-through escapes
  // and \u escapes of one, two and three UTF-8 bytes. With bad_hex a broken \u escape ends
  // the body, so the decoder reports an error and drains the rest of the line.
  task automatic add_string(input int body_len, input bit bad_hex);
    int         r;
    logic [7:0] b;
    logic [15:0] cp;
    line_q.push_back(ChQuote);
    for (int i = 0; i < body_len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        do b = 8'($urandom_range(0, 255));
        while (b == ChQuote || b == ChBslash);
        line_q.push_back(b);
      end else if (r < 75) begin
        line_q.push_back(ChBslash);
        case ($urandom_range(0, 8))
          0: b = ChQuote;
          1: b = ChBslash;
          2: b = "/";
          3: b = "n";
          4: b = "r";
          5: b = "t";
          6: b = "b";
          7: b = "f";
          default: begin
            do b = 8'($urandom_range(0, 255));
            while (b == "u");
          end
        endcase
        line_q.push_back(b);
      end else begin
        case ($urandom_range(0, 2))
          0: cp = 16'($urandom_range(0, 'h7F));
          1: cp = 16'($urandom_range('h80, 'h7FF));
          default: cp = 16'($urandom_range('h800, 'hFFFF));
        endcase
        push_unicode(cp, -1);
      end
    end
    if (bad_hex) push_unicode(16'($urandom), $urandom_range(0, 3));
    line_q.push_back(ChQuote);
  endtask

  // Random line: mostly well-formed strings, some broken ones (bad hex digit or a line
  // that stops early anywhere, including on the opening quote or inside a \u escape),
  // and some raw noise.
  task automatic gen_line();
    int r;
    int n;
    r = $urandom_range(0, 99);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: line_q.push_back(ChSpace);
        1: line_q.push_back(ChTab);
        2: line_q.push_back(ChLf);
        default: line_q.push_back(ChCr);
      endcase
    end
    if (r < 65) begin
      add_string($urandom_range(0, 10), 1'b0);
      // A second string on the same line starts from idle again.
      if ($urandom_range(0, 4) == 0) add_string($urandom_range(0, 4), 1'b0);
    end else if (r < 72) begin
      add_string($urandom_range(0, 6), 1'b1);
    end else if (r < 85) begin
      add_string($urandom_range(0, 8), 1'b0);
      n = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > n) void'(line_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    send_line();
  endtask

  // Stop offering bytes and wait until every expected result has been transferred, then
  // give the block time to finish bytes that cause no result.
  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Receiver: pop follows a pattern that is redrawn each time its countdown runs out (always
  // ready, coin flip, mostly stalled, or ready when the countdown is a multiple of three). When
  // asked it holds off for a long stretch so that the block fills up and raises full.
  initial begin : receiver
    int mode;
    int left;
    pop  = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_rx = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (left % 3 == 0);
      endcase
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [8:0] caps[7];
    int         target;
    caps = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd5, 9'd0, 9'd128};
    caps[5] = 9'($urandom_range(2, 255));
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 9'd0;
    push      = 1'b0;
    in_byte   = 8'h00;
    line_end  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity. First a good string: leading whitespace, the
    // byte extremes, a short escape, a pass-through escape, and \u escapes that become two
    // and three UTF-8 bytes.
    push_text("\t\"");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    push_text("\\b\\q\\u07fF\\uFFFF\"");
    send_line();
    // Non-quote start ending the line, whitespace ending the line, and a bad hex digit
    // whose line is drained up to the closing quote.
    push_text("x");
    send_line();
    push_text(" ");
    send_line();
    push_text("\"\\u0g\"");
    send_line();

    // Random phases, each at its own capacity; the register is written only once the block
    // has gone quiet. The phases cover no room at all, the largest size, a value above it,
    // and small sizes where multi-byte characters get dropped.
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      cfg_we    <= 1'b1;
      cfg_wdata <= caps[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      if (caps[p] == 9'd256) begin
        // Receiver holds off while the sender keeps offering a long string.
        hold_rx = 1'b1;
        add_string(16, 1'b0);
        send_line();
      end
      target = sent + PhaseItems;
      while (sent < target) gen_line();
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
